FILE: src/rdwr_pkg.sv
package rdwr_pkg;

	// Deck geometry: one card per entry, cards are entry indexes.
	localparam int DECK_DEPTH = 256;
	localparam int IDX_W      = $clog2(DECK_DEPTH);
	localparam int CNT_W      = $clog2(DECK_DEPTH + 1);
	localparam int CARD_W     = 8;

	// Random generator width and constants.
	localparam int SEED_W = 31;
	localparam logic [SEED_W-1:0] LCG_MUL = 31'd1103515245;
	localparam logic [SEED_W-1:0] LCG_ADD = 31'd12345;

	// Iteration count of the remainder unit, one dividend bit per cycle.
	localparam int MOD_STEPS = SEED_W;
	localparam int STEP_W    = $clog2(MOD_STEPS + 1);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_DECK_SIZE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_SEED = 1'd1;

	// Control from the sequencer to the remainder unit.
	typedef struct packed {
		logic start;
	} mod_ctrl_t;

	// Status from the remainder unit back to the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} mod_stat_t;

endpackage

FILE: src/random_draw_without_replacement_core.sv
// Urn draw without replacement. The deck holds the cards 0 to deck_size-1; each
// transfer on the input channel yields exactly one transfer on the output channel
// carrying the most recently drawn card and a flag that is high when a trigger
// found the deck empty and refilled it. A triggered item steps a 31-bit linear
// congruential generator, then reduces the new state modulo the remaining card
// count in a bit-serial remainder unit (one dividend bit per step), then reads
// the chosen card and the last card through the read port of the deck memory and
// writes the last card into the hole, before the result goes to the output
// register. An item without trigger goes straight to the done state. The input is
// taken again as soon as the result sits in the output register; no new item is
// taken while one is in flight. A refill, by restart, by an empty deck or by a
// deck_size write, clears the per-entry valid bits at once, and an entry not yet
// rewritten reads as its index.
module random_draw_without_replacement_core
	import rdwr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port.
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SEED_W-1:0]    cfg_data,
	// Input channel.
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 trigger,
	input  logic [SEED_W-1:0]    reseed_value,
	input  logic                 restart,
	// Output channel.
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CARD_W-1:0]    drawn_value,
	output logic                 refilled
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LCG,
		ST_MOD_START,
		ST_MOD_WAIT,
		ST_RD_POS,
		ST_RD_LAST,
		ST_WRITE,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     deck_size_q;
	logic [CNT_W-1:0]     remaining_q;
	logic [SEED_W-1:0]    random_state_q;
	logic [SEED_W-1:0]    reseed_q;
	logic [IDX_W-1:0]     last_drawn_q;
	logic [IDX_W-1:0]     pos_q;
	logic                 refilled_q;
	logic [DECK_DEPTH-1:0] valid_q;
	logic                 out_valid_q;
	logic [CARD_W-1:0]    drawn_value_q;
	logic                 out_refilled_q;

	logic [IDX_W-1:0]     mem_q [DECK_DEPTH];
	logic [IDX_W-1:0]     mem_rd_q;
	logic [IDX_W-1:0]     rd_addr;
	logic                 mem_we;

	logic [SEED_W-1:0]    lcg_next;
	logic [IDX_W-1:0]     last_idx;
	logic [IDX_W-1:0]     pos_card;
	logic [IDX_W-1:0]     last_card;
	logic [CNT_W-1:0]     rem_eff;
	logic                 empty_hit;
	logic [CNT_W-1:0]     cfg_size;
	logic                 out_load;

	mod_ctrl_t            mod_ctrl;
	mod_stat_t            mod_stat;
	logic [IDX_W-1:0]     mod_rem;

	// Generator step; only the low 31 bits of the product are kept.
	assign lcg_next = random_state_q * LCG_MUL + LCG_ADD;

	// Deck addressing. A card that was never rewritten since the last refill is its index.
	assign last_idx  = IDX_W'(remaining_q - 1'b1);
	assign pos_card  = valid_q[pos_q] ? mem_rd_q : pos_q;
	assign last_card = valid_q[last_idx] ? mem_rd_q : last_idx;
	assign rd_addr   = (state_q == ST_RD_POS) ? pos_q : last_idx;
	assign mem_we    = (state_q == ST_WRITE);

	// Count seen by the trigger after an optional restart refill.
	assign rem_eff   = restart ? deck_size_q : remaining_q;
	assign empty_hit = trigger && (rem_eff == '0);

	// Deck size write: only the low CNT_W bits count; a zero there is ignored, larger values saturate at DECK_DEPTH.
	assign cfg_size = (cfg_data[CNT_W-1:0] > CNT_W'(DECK_DEPTH)) ?
		CNT_W'(DECK_DEPTH) : cfg_data[CNT_W-1:0];

	// The output register takes a new result when it is empty or being emptied.
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign mod_ctrl.start = (state_q == ST_MOD_START);

	rdwr_modulo u_modulo (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (mod_ctrl),
		.dividend  (random_state_q),
		.divisor   (remaining_q),
		.stat      (mod_stat),
		.remainder (mod_rem)
	);

	// Deck memory: one registered read per cycle, plus one write when mem_we is high.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[pos_q] <= last_card;
		end
		mem_rd_q <= mem_q[rd_addr];
	end

	// Sequencer, deck bookkeeping, configuration and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			deck_size_q    <= CNT_W'(1);
			remaining_q    <= CNT_W'(1);
			random_state_q <= SEED_W'(1);
			reseed_q       <= '0;
			pos_q          <= '0;
			last_drawn_q   <= '0;
			valid_q        <= '0;
			refilled_q     <= 1'b0;
			out_valid_q    <= 1'b0;
			out_refilled_q <= 1'b0;
			drawn_value_q  <= '0;
		end else begin
			if (out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						reseed_q   <= reseed_value;
						refilled_q <= empty_hit;
						if (restart || empty_hit) begin
							valid_q     <= '0;
							remaining_q <= deck_size_q;
						end
						state_q <= trigger ? ST_LCG : ST_DONE;
					end
				end
				ST_LCG: begin
					random_state_q <= lcg_next;
					state_q        <= ST_MOD_START;
				end
				ST_MOD_START: begin
					state_q <= ST_MOD_WAIT;
				end
				ST_MOD_WAIT: begin
					if (mod_stat.done) begin
						pos_q   <= mod_rem;
						state_q <= ST_RD_POS;
					end
				end
				ST_RD_POS: begin
					state_q <= ST_RD_LAST;
				end
				ST_RD_LAST: begin
					last_drawn_q <= pos_card;
					state_q      <= ST_WRITE;
				end
				ST_WRITE: begin
					valid_q[pos_q] <= 1'b1;
					remaining_q    <= remaining_q - 1'b1;
					if (reseed_q != '0) begin
						random_state_q <= reseed_q;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						out_valid_q    <= 1'b1;
						drawn_value_q  <= CARD_W'(last_drawn_q);
						out_refilled_q <= refilled_q;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// The user must write registers only while the block is idle; the block itself does not enforce it.
			if (cfg_we) begin
				if (cfg_index == REG_DECK_SIZE) begin
					if (cfg_data[CNT_W-1:0] != '0) begin
						deck_size_q <= cfg_size;
						remaining_q <= cfg_size;
						valid_q     <= '0;
					end
				end else if (cfg_index == REG_START_SEED) begin
					random_state_q <= cfg_data;
				end
			end
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign drawn_value = drawn_value_q;
	assign refilled    = out_refilled_q;

	// The block does not take input in the cycle after a transfer.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on consecutive cycles");

	// The remaining count never exceeds the deck depth.
	a_remaining_bound: assert property (@(posedge clk) disable iff (!arst_n)
		remaining_q <= CNT_W'(DECK_DEPTH))
		else $error("remaining count above deck depth");

	// The chosen position always lies inside the remaining cards.
	a_pos_in_deck: assert property (@(posedge clk) disable iff (!arst_n)
		mod_stat.done |-> (CNT_W'(mod_rem) < remaining_q))
		else $error("drawn position outside remaining cards");

	// The remainder unit is never restarted while it is still stepping.
	a_mod_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mod_ctrl.start |-> !mod_stat.busy)
		else $error("remainder unit started while busy");

endmodule

FILE: src/rdwr_modulo.sv
module rdwr_modulo
	import rdwr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  mod_ctrl_t         ctrl,
	input  logic [SEED_W-1:0] dividend,
	input  logic [CNT_W-1:0]  divisor,
	output mod_stat_t         stat,
	output logic [IDX_W-1:0]  remainder
);

	logic [SEED_W-1:0] dividend_q;
	logic [CNT_W-1:0]  rem_q;
	logic [STEP_W-1:0] steps_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  trial;
	logic [CNT_W-1:0]  next_rem;

	// One restoring step: bring down the next dividend bit and subtract if it fits.
	// The partial remainder stays below the divisor, so it fits in IDX_W bits.
	always_comb begin
		trial = {rem_q[IDX_W-1:0], dividend_q[SEED_W-1]};
		if (trial >= divisor) begin
			next_rem = trial - divisor;
		end else begin
			next_rem = trial;
		end
	end

	// Step sequencer: loads on start, runs MOD_STEPS steps, pulses done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			steps_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q  <= 1'b1;
				steps_q <= STEP_W'(MOD_STEPS);
			end else if (busy_q) begin
				steps_q <= steps_q - 1'b1;
				if (steps_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			dividend_q <= dividend;
			rem_q      <= '0;
		end else if (busy_q) begin
			dividend_q <= {dividend_q[SEED_W-2:0], 1'b0};
			rem_q      <= next_rem;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = rem_q[IDX_W-1:0];

endmodule
